@@ sv/bls_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the bilinear sampler
// used by bls_blend, the top level and the testbench; depends on nothing

package bls_pkg;

    // default sizes, handed to the top level as parameter defaults
    localparam int DEF_MAX_COLS  = 512;
    localparam int DEF_MAX_ROWS  = 512;
    localparam int DEF_FRAC_BITS = 8;

    // widths of the item fields
    localparam int ACTION_W  = 1;
    localparam int PIX_COL_W = 9;
    localparam int PIX_ROW_W = 9;
    localparam int PIX_VAL_W = 8;
    localparam int SAMPLE_W  = 18;
    localparam int VALUE_W   = 16;
    localparam int CFG_W     = 10;

    // bit positions inside the input tdata
    localparam int PIX_COL_LSB = 0;
    localparam int PIX_ROW_LSB = PIX_COL_LSB + PIX_COL_W;
    localparam int PIX_VAL_LSB = PIX_ROW_LSB + PIX_ROW_W;
    localparam int SMP_U_LSB   = PIX_VAL_LSB + PIX_VAL_W;
    localparam int SMP_V_LSB   = SMP_U_LSB + SAMPLE_W;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 16;

    // item kinds
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // configuration register indexes and reset value
    localparam logic             CFG_IMAGE_COLS = 1'b0;
    localparam logic             CFG_IMAGE_ROWS = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET      = 10'd512;

    // bank select and border status of a sample on its way through the pipe
    typedef struct packed {
        logic valid;
        logic in_range;
        logic odd_col;
        logic odd_row;
    } t_smp_ctl;

    // one finished result
    typedef struct packed {
        logic               valid;
        logic               in_range;
        logic [VALUE_W-1:0] value;
    } t_result;

endpackage

@@ sv/bls_bank.sv @@
`timescale 1ns / 1ps
// one parity bank of the pixel store: single port, registered read
// standalone; no package needed

module bls_bank #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ sv/bls_blend.sv @@
`timescale 1ns / 1ps
// two-stage weighting of the four neighbour pixels: horizontal pass, then vertical
// depends on bls_pkg for the control and result structs

module bls_blend #(
    parameter int FRAC_BITS = bls_pkg::DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  bls_pkg::t_smp_ctl     i_ctl,
    input  logic [FRAC_BITS-1:0]  i_du,
    input  logic [FRAC_BITS-1:0]  i_dv,
    input  logic [3:0][7:0]       i_pix,    // indexed by {row parity, col parity}
    output bls_pkg::t_result      o_res
);
    import bls_pkg::*;

    localparam int HW = FRAC_BITS + 8;
    localparam int SW = 2 * FRAC_BITS + 8;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [7:0]           w_p00, w_p01, w_p10, w_p11;
    logic [FRAC_BITS:0]   w_wu0, w_wu1, w_wv0, w_wv1;
    logic [HW:0]          w_h0, w_h1;
    logic [SW:0]          w_sum;
    logic [31:0]          w_q;

    logic                 r_v2, r_rng2;
    logic [FRAC_BITS-1:0] r_dv2;
    logic [HW-1:0]        r_h0, r_h1;
    t_result              r_res;
    t_result              n_res;

    // route banks to neighbour positions by parity of the integer parts
    assign w_p00 = i_pix[{i_ctl.odd_row, i_ctl.odd_col}];
    assign w_p01 = i_pix[{i_ctl.odd_row, ~i_ctl.odd_col}];
    assign w_p10 = i_pix[{~i_ctl.odd_row, i_ctl.odd_col}];
    assign w_p11 = i_pix[{~i_ctl.odd_row, ~i_ctl.odd_col}];

    // horizontal weights and row blends
    assign w_wu0 = ONE - {1'b0, i_du};
    assign w_wu1 = {1'b0, i_du};
    assign w_h0  = w_wu0 * w_p00 + w_wu1 * w_p01;
    assign w_h1  = w_wu0 * w_p10 + w_wu1 * w_p11;

    // vertical blend of the two rows, truncated back to the output scale
    assign w_wv0 = ONE - {1'b0, r_dv2};
    assign w_wv1 = {1'b0, r_dv2};
    assign w_sum = w_wv0 * r_h0 + w_wv1 * r_h1;
    assign w_q   = 32'(w_sum >> FRAC_BITS);

    always_comb begin
        n_res.valid    = r_v2;
        n_res.in_range = r_rng2;
        n_res.value    = r_rng2 ? w_q[VALUE_W-1:0] : '0;
    end

    // stage payload and stage valids
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rng2         <= i_ctl.in_range;
            r_dv2          <= i_dv;
            r_h0           <= HW'(w_h0);
            r_h1           <= HW'(w_h1);
            r_res.in_range <= n_res.in_range;
            r_res.value    <= n_res.value;
        end
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            r_v2        <= i_ctl.valid;
            r_res.valid <= n_res.valid;
        end
    end

    assign o_res = r_res;

endmodule

@@ sv/bilinear_sampler_u8.sv @@
`timescale 1ns / 1ps
// top level of the bilinear sampler: item decode, four parity banks, output skid
// depends on bls_pkg, bls_bank and bls_blend
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------------
//  s (input) | in        | i_s_tvalid / o_s_tready   | i_s_tdata, i_s_tuser (action)
//  m (output)| out       | o_m_tvalid / i_m_tready   | o_m_tdata, o_m_tuser (in_range)
//  cfg       | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// one item per cycle while the skid register is empty; a sample's result passes the bank read,
// row blend, column blend and output registers in turn; a write gives no result
// the store is split into four banks by row and column parity, so the 2x2
// neighbourhood is one read from each bank in the same cycle
// reset clears control and sets the image size registers to 512; the store is not cleared
// a stalled output fills the skid register first, then input stops

module bilinear_sampler_u8 #(
    parameter int MAX_COLS  = bls_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS  = bls_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = bls_pkg::DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // pixel_col, pixel_row, pixel_value, sample_u, sample_v, zero fill
    input  logic [bls_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action
    input  logic                          i_s_tuser,
    // result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // interp_value
    output logic [bls_pkg::M_TDATA_W-1:0] o_m_tdata,
    // in_range
    output logic                          o_m_tuser,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [bls_pkg::CFG_W-1:0]     i_cfg_data
);
    import bls_pkg::*;

    localparam int CHW = $clog2((MAX_COLS + 1) / 2);
    localparam int RHW = $clog2((MAX_ROWS + 1) / 2);
    localparam int AW  = CHW + RHW;

    // configuration
    logic [CFG_W-1:0] r_cols, r_rows;

    // input decode
    logic                        w_accept, w_en;
    logic [PIX_COL_W-1:0]        w_pcol;
    logic [PIX_ROW_W-1:0]        w_prow;
    logic [PIX_VAL_W-1:0]        w_pval;
    logic signed [SAMPLE_W-1:0]  w_su, w_sv, w_iu, w_iv;
    logic signed [SAMPLE_W-1:0]  w_col_hi, w_row_hi;
    logic [SAMPLE_W-1:0]         w_cols_c, w_rows_c;
    logic [SAMPLE_W-1:0]         w_col_ev, w_col_od, w_row_ev, w_row_od;
    logic [SAMPLE_W-1:0]         w_wcol_h, w_wrow_h;
    logic                        w_wr_ok, w_in_range;
    logic [1:0]                  w_wsel;
    logic [3:0][7:0]             w_pix;

    // pipeline and output
    t_smp_ctl             r_ctl1;
    logic [FRAC_BITS-1:0] r_du1, r_dv1;
    t_result              w_res;
    logic                 r_out_v, r_skid_v;
    logic [VALUE_W-1:0]   r_out_val, r_skid_val;
    logic                 r_out_rng, r_skid_rng;
    logic                 w_push, w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_RESET;
            r_rows <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_COLS: r_cols <= i_cfg_data;
                CFG_IMAGE_ROWS: r_rows <= i_cfg_data;
            endcase
        end
    end

    // the whole pipe moves unless the skid register is holding a result
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;
    assign w_accept   = i_s_tvalid && w_en;

    // field decode
    assign w_pcol = i_s_tdata[PIX_COL_LSB +: PIX_COL_W];
    assign w_prow = i_s_tdata[PIX_ROW_LSB +: PIX_ROW_W];
    assign w_pval = i_s_tdata[PIX_VAL_LSB +: PIX_VAL_W];
    assign w_su   = $signed(i_s_tdata[SMP_U_LSB +: SAMPLE_W]);
    assign w_sv   = $signed(i_s_tdata[SMP_V_LSB +: SAMPLE_W]);

    // floor to integer parts
    assign w_iu = w_su >>> FRAC_BITS;
    assign w_iv = w_sv >>> FRAC_BITS;

    // border check against the clamped image size
    assign w_cols_c = (SAMPLE_W'(r_cols) > SAMPLE_W'(MAX_COLS)) ?
                      SAMPLE_W'(MAX_COLS) : SAMPLE_W'(r_cols);
    assign w_rows_c = (SAMPLE_W'(r_rows) > SAMPLE_W'(MAX_ROWS)) ?
                      SAMPLE_W'(MAX_ROWS) : SAMPLE_W'(r_rows);
    assign w_col_hi = $signed(w_cols_c - SAMPLE_W'(2));
    assign w_row_hi = $signed(w_rows_c - SAMPLE_W'(2));
    assign w_in_range = !w_iu[SAMPLE_W-1] && (w_iu != '0) && (w_iu <= w_col_hi) &&
                        !w_iv[SAMPLE_W-1] && (w_iv != '0) && (w_iv <= w_row_hi);

    // half coordinates of the even and odd neighbour in each axis
    assign w_col_od = SAMPLE_W'(w_iu) >> 1;
    assign w_col_ev = (SAMPLE_W'(w_iu) + SAMPLE_W'(w_iu[0])) >> 1;
    assign w_row_od = SAMPLE_W'(w_iv) >> 1;
    assign w_row_ev = (SAMPLE_W'(w_iv) + SAMPLE_W'(w_iv[0])) >> 1;

    // write address and bank
    assign w_wcol_h = SAMPLE_W'(w_pcol >> 1);
    assign w_wrow_h = SAMPLE_W'(w_prow >> 1);
    assign w_wsel   = {w_prow[0], w_pcol[0]};
    assign w_wr_ok  = (32'(w_pcol) < 32'(MAX_COLS)) && (32'(w_prow) < 32'(MAX_ROWS));

    // four parity banks; items enter one per cycle, so a read never meets a
    // write in the same cycle and a write is visible to the next item
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        logic [AW-1:0] w_addr;
        logic          w_we, w_re;

        always_comb begin
            if (i_s_tuser == ACT_SAMPLE) begin
                w_addr = {(gb[1] ? w_row_od[RHW-1:0] : w_row_ev[RHW-1:0]),
                          (gb[0] ? w_col_od[CHW-1:0] : w_col_ev[CHW-1:0])};
            end else begin
                w_addr = {w_wrow_h[RHW-1:0], w_wcol_h[CHW-1:0]};
            end
        end

        assign w_we = w_accept && (i_s_tuser == ACT_WRITE) && w_wr_ok && (w_wsel == 2'(gb));
        assign w_re = w_accept && (i_s_tuser == ACT_SAMPLE);

        bls_bank #(
            .AW (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_re    (w_re),
            .i_addr  (w_addr),
            .i_wdata (w_pval),
            .o_rdata (w_pix[gb])
        );
    end

    // stage alongside the bank read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl1.in_range <= w_in_range;
            r_ctl1.odd_col  <= w_iu[0];
            r_ctl1.odd_row  <= w_iv[0];
            r_du1           <= w_su[FRAC_BITS-1:0];
            r_dv1           <= w_sv[FRAC_BITS-1:0];
        end
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (w_en) begin
            r_ctl1.valid <= w_accept && (i_s_tuser == ACT_SAMPLE);
        end
    end

    // weighting of the neighbourhood
    bls_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_ctl1),
        .i_du    (r_du1),
        .i_dv    (r_dv1),
        .i_pix   (w_pix),
        .o_res   (w_res)
    );

    // output register with skid stage
    assign w_push = w_en && w_res.valid;
    assign w_pop  = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (w_pop) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end
            end else if (w_push) begin
                if (r_out_v && !w_pop) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out_val <= r_skid_val;
                r_out_rng <= r_skid_rng;
            end
        end else if (w_push) begin
            if (r_out_v && !w_pop) begin
                r_skid_val <= w_res.value;
                r_skid_rng <= w_res.in_range;
            end else begin
                r_out_val <= w_res.value;
                r_out_rng <= w_res.in_range;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_val;
    assign o_m_tuser  = r_out_rng;

    // the skid register only fills behind a waiting output
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    // a held skid result keeps input closed
    a_skid_blocks_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !o_s_tready)
        else $error("input ready while skid register full");

    // an accepted sample enters the bank read stage
    a_sample_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == ACT_SAMPLE)) |=> r_ctl1.valid)
        else $error("accepted sample lost at bank read");

    // a result outside the border carries zero
    a_border_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nonzero value on out-of-border result");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for bilinear_sampler_u8: random and directed items, scoreboard
// depends on bls_pkg and the bilinear_sampler_u8 top level

module testbench;
    import bls_pkg::*;

    localparam int MAX_COLS       = DEF_MAX_COLS;
    localparam int MAX_ROWS       = DEF_MAX_ROWS;
    localparam int FRAC_BITS      = DEF_FRAC_BITS;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               in_range;
    } t_sample_result;

    logic                 i_clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = ACT_WRITE;
    logic                 m_tready = 1'b1;
    logic                 cfg_we   = 1'b0;
    logic                 cfg_idx  = CFG_IMAGE_COLS;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;

    // mirror of the block: image, written map and size registers
    logic [7:0]       image_model [MAX_COLS*MAX_ROWS];
    bit               pixel_written [MAX_COLS*MAX_ROWS];
    logic [CFG_W-1:0] model_cols;
    logic [CFG_W-1:0] model_rows;

    t_sample_result expected_samples[$];
    int unsigned    items_sent  = 0;
    int unsigned    error_count = 0;
    int unsigned    result_count = 0;
    bit             quiet_mode  = 1'b0;
    int             stall_left  = 0;
    int             win_col     = 1;
    int             win_row     = 1;

    bilinear_sampler_u8 #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int limit_size(logic [CFG_W-1:0] reg_value, int max_size);
        return (reg_value > max_size) ? max_size : int'(reg_value);
    endfunction

    function automatic int floor_pos(logic [SAMPLE_W-1:0] p);
        int i;
        i = int'($signed(p));
        return i >>> FRAC_BITS;
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_fixed(int i, int frac);
        return SAMPLE_W'(i * ONE + frac);
    endfunction

    // true when the whole 2x2 neighbourhood lies inside the border
    function automatic bit inside_border(int iu, int iv);
        return iu >= 1 && iv >= 1 &&
               iu <= limit_size(model_cols, MAX_COLS) - 2 &&
               iv <= limit_size(model_rows, MAX_ROWS) - 2;
    endfunction

    // expected result of a sample at (u, v) with the current image
    function automatic t_sample_result interpolate(logic [SAMPLE_W-1:0] u,
                                                   logic [SAMPLE_W-1:0] v);
        t_sample_result  res;
        int              iu, iv, base;
        longint unsigned du, dv, acc;
        iu = floor_pos(u);
        iv = floor_pos(v);
        du = 64'(u[FRAC_BITS-1:0]);
        dv = 64'(v[FRAC_BITS-1:0]);
        res = '0;
        if (inside_border(iu, iv)) begin
            base = iv * MAX_COLS + iu;
            acc = (ONE - du) * (ONE - dv) * image_model[base]
                + du * (ONE - dv) * image_model[base + 1]
                + (ONE - du) * dv * image_model[base + MAX_COLS]
                + du * dv * image_model[base + MAX_COLS + 1];
            res.value    = acc[FRAC_BITS +: VALUE_W];
            res.in_range = 1'b1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    // send one item and update the mirror when it is taken
    task automatic send_item(input logic act, input logic [PIX_COL_W-1:0] col,
                             input logic [PIX_ROW_W-1:0] row, input logic [PIX_VAL_W-1:0] val,
                             input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] v);
        int                   gap;
        logic [S_TDATA_W-1:0] data;
        gap  = pick_gap();
        data = '0;
        data[PIX_COL_LSB +: PIX_COL_W] = col;
        data[PIX_ROW_LSB +: PIX_ROW_W] = row;
        data[PIX_VAL_LSB +: PIX_VAL_W] = val;
        data[SMP_U_LSB +: SAMPLE_W]    = u;
        data[SMP_V_LSB +: SAMPLE_W]    = v;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (act == ACT_WRITE) begin
            image_model[row * MAX_COLS + col]   = val;
            pixel_written[row * MAX_COLS + col] = 1'b1;
        end else begin
            expected_samples.push_back(interpolate(u, v));
        end
        items_sent++;
    endtask

    task automatic write_pixel(input int col, input int row, input int val);
        send_item(ACT_WRITE, PIX_COL_W'(col), PIX_ROW_W'(row), PIX_VAL_W'(val),
                  SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
    endtask

    // write any pixel of the neighbourhood that holds nothing yet
    task automatic cover_neighbourhood(input int iu, input int iv);
        for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
                if (!pixel_written[(iv + dr) * MAX_COLS + iu + dc])
                    write_pixel(iu + dc, iv + dr, $urandom_range(0, 255));
    endtask

    task automatic sample_at(input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] v);
        if (inside_border(floor_pos(u), floor_pos(v)))
            cover_neighbourhood(floor_pos(u), floor_pos(v));
        send_item(ACT_SAMPLE, PIX_COL_W'($urandom()), PIX_ROW_W'($urandom()),
                  PIX_VAL_W'($urandom()), u, v);
    endtask

    // hold off input until every result is in and the pipe is empty
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_IMAGE_COLS) model_cols = value;
        else model_rows = value;
    endtask

    task automatic configure(input bit set_cols, input logic [CFG_W-1:0] cols,
                             input bit set_rows, input logic [CFG_W-1:0] rows);
        drain_results();
        if (set_cols) write_register(CFG_IMAGE_COLS, cols);
        if (set_rows) write_register(CFG_IMAGE_ROWS, rows);
        cfg_we <= 1'b0;
    endtask

    // coordinate on or near an edge of an axis of the given size, or now and then a random inner one
    function automatic int border_pick(int size);
        case ($urandom_range(0, 6))
            0: return -1;
            1: return 0;
            2: return 1;
            3: return size - 2;
            4: return size - 1;
            5: return (size > 511) ? 511 : size;
            default: return (size >= 3) ? $urandom_range(1, size - 2) : 1;
        endcase
    endfunction

    // one random item, local mode stays inside a small window of the image
    task automatic random_item(input bit local_mode);
        int pick, cols, rows;
        cols = limit_size(model_cols, MAX_COLS);
        rows = limit_size(model_rows, MAX_ROWS);
        pick = $urandom_range(0, 99);
        if (local_mode) begin
            if (pick < 40)
                write_pixel(win_col + $urandom_range(0, 5), win_row + $urandom_range(0, 5),
                            $urandom_range(0, 255));
            else
                sample_at(to_fixed(win_col + $urandom_range(0, 4), $urandom_range(0, ONE - 1)),
                          to_fixed(win_row + $urandom_range(0, 4), $urandom_range(0, ONE - 1)));
        end else if (pick < 25) begin
            write_pixel($urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
                        $urandom_range(0, 255));
        end else if (pick < 80 && cols >= 3 && rows >= 3) begin
            sample_at(to_fixed($urandom_range(1, cols - 2), $urandom_range(0, ONE - 1)),
                      to_fixed($urandom_range(1, rows - 2), $urandom_range(0, ONE - 1)));
        end else if (pick < 93) begin
            sample_at(to_fixed(border_pick(cols), $urandom_range(0, ONE - 1)),
                      to_fixed(border_pick(rows), $urandom_range(0, ONE - 1)));
        end else begin
            sample_at(SAMPLE_W'($urandom()), SAMPLE_W'($urandom()));
        end
    endtask

    task automatic run_random(input int unsigned count, input bit local_mode);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target) random_item(local_mode);
    endtask

    // corners of the full-size image, exact and maximal fractions, far positions
    task automatic test_border_extremes();
        write_pixel(1, 1, 255);
        write_pixel(2, 1, 255);
        write_pixel(1, 2, 255);
        write_pixel(2, 2, 255);
        write_pixel(510, 510, 0);
        write_pixel(511, 510, 255);
        write_pixel(510, 511, 128);
        write_pixel(511, 511, 1);
        write_pixel(0, 0, 8'h5a);
        write_pixel(511, 0, 8'ha5);
        sample_at(to_fixed(1, 0), to_fixed(1, 0));
        sample_at(to_fixed(1, ONE - 1), to_fixed(1, ONE - 1));
        sample_at(to_fixed(2, 0), to_fixed(1, ONE / 2));
        sample_at(to_fixed(510, ONE - 1), to_fixed(510, ONE - 1));
        sample_at(to_fixed(510, ONE / 2), to_fixed(510, ONE / 2));
        sample_at(to_fixed(511, 0), to_fixed(510, 0));
        sample_at(to_fixed(510, 0), to_fixed(511, 0));
        sample_at(to_fixed(0, ONE - 1), to_fixed(1, 0));
        sample_at(to_fixed(1, 0), to_fixed(0, ONE - 1));
        sample_at({SAMPLE_W{1'b1}}, to_fixed(1, 0));
        sample_at({1'b1, {(SAMPLE_W-1){1'b0}}}, {1'b1, {(SAMPLE_W-1){1'b0}}});
        sample_at({1'b0, {(SAMPLE_W-1){1'b1}}}, {1'b0, {(SAMPLE_W-1){1'b1}}});
    endtask

    // smallest, tiny, oversized and lopsided image sizes
    task automatic test_register_extremes();
        configure(1'b1, 10'd3, 1'b1, 10'd3);
        sample_at(to_fixed(1, ONE - 1), to_fixed(1, 3));
        sample_at(to_fixed(2, 0), to_fixed(1, 0));
        run_random(25, 1'b0);
        configure(1'b1, 10'd0, 1'b1, 10'd0);
        run_random(20, 1'b0);
        configure(1'b1, 10'd1, 1'b0, 10'd0);
        run_random(15, 1'b0);
        configure(1'b1, 10'd2, 1'b1, 10'd2);
        run_random(15, 1'b0);
        configure(1'b1, 10'd1023, 1'b1, 10'd1023);
        sample_at(to_fixed(510, ONE - 1), to_fixed(510, 7));
        sample_at(to_fixed(511, 0), to_fixed(100, 0));
        run_random(25, 1'b0);
        configure(1'b1, 10'd513, 1'b1, 10'd4);
        run_random(25, 1'b0);
        configure(1'b0, 10'd0, 1'b1, 10'd700);
        run_random(25, 1'b0);
    endtask

    // rewrites of pixels right before and between samples that read them
    task automatic test_write_then_sample();
        configure(1'b1, 10'd512, 1'b1, 10'd512);
        for (int w = 0; w < 6; w++) begin
            quiet_mode = (w % 2 == 0);
            win_col = $urandom_range(1, MAX_COLS - 6);
            win_row = $urandom_range(1, MAX_ROWS - 6);
            run_random(50, 1'b1);
        end
        quiet_mode = 1'b0;
    endtask

    // long random run across several image sizes
    task automatic test_random_mix();
        logic [CFG_W-1:0] cols_list [8] = '{10'd512, 10'd3, 10'd512, 10'd1023,
                                            10'd600, 10'd4, 10'd40, 10'd257};
        logic [CFG_W-1:0] rows_list [8] = '{10'd512, 10'd512, 10'd3, 10'd800,
                                            10'd5, 10'd4, 10'd300, 10'd33};
        for (int p = 0; p < 11; p++) begin
            if (p < 8) configure(1'b1, cols_list[p], 1'b1, rows_list[p]);
            else configure(1'b1, CFG_W'($urandom_range(3, 512)),
                           1'b1, CFG_W'($urandom_range(3, 512)));
            quiet_mode = ($urandom_range(0, 3) == 0);
            run_random(100, 1'b0);
        end
        quiet_mode = 1'b0;
    endtask

    // result side stalls
    always @(posedge i_clk) begin : result_backpressure
        int n;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            n = pick_gap();
            if (n > 0) begin
                stall_left = n - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare every result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_sample_result want;
        if (rst_n && o_m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected result, value", int'(o_m_tdata), 0);
            end else begin
                want = expected_samples.pop_front();
                if (o_m_tdata !== want.value)
                    report_mismatch("interp_value", int'(o_m_tdata), int'(want.value));
                if (o_m_tuser !== want.in_range)
                    report_mismatch("in_range", int'(o_m_tuser), int'(want.in_range));
            end
            result_count++;
        end
    end

    // stop the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // reset, then the tests in turn
    initial begin
        model_cols = CFG_RESET;
        model_rows = CFG_RESET;
        foreach (pixel_written[i]) begin
            pixel_written[i] = 1'b0;
            image_model[i]   = '0;
        end
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_border_extremes();
        test_register_extremes();
        test_write_then_sample();
        test_random_mix();
        drain_results();
        if (error_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/bls_pkg.sv
sv/bls_bank.sv
sv/bls_blend.sv
sv/bilinear_sampler_u8.sv
verif/testbench.sv
